FILE: design/assert_macros.svh
// assertion macros shared by the filter's rtl files
// no dependencies; assertions compile out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property checked on every clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// property checked on every clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`else

`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

FILE: design/mplf_pkg.sv
// shared constants, types and helpers of the multi-pattern line filter
// no dependencies
package mplf_pkg;

  // sizing
  localparam int MaxPatternChars = 8;
  localparam int MaxPatterns     = 4;
  localparam int CharW           = 8;
  localparam int LenW            = 4;
  localparam int CountW          = 3;
  localparam int IndexW          = 3;
  localparam int DataW           = 64;

  // configuration register indexes
  localparam logic [IndexW-1:0] RegPatternCount   = 3'd0;
  localparam logic [IndexW-1:0] RegPatternZero    = 3'd1;
  localparam logic [IndexW-1:0] RegPatternOne     = 3'd2;
  localparam logic [IndexW-1:0] RegPatternTwo     = 3'd3;
  localparam logic [IndexW-1:0] RegPatternThree   = 3'd4;
  localparam logic [IndexW-1:0] RegPatternLengths = 3'd5;

  // reset value of the pattern count register
  localparam logic [CountW-1:0] CountReset = 3'd1;

  // ascii letter bounds for case folding
  localparam logic [CharW-1:0] UpperFirst = 8'h41;
  localparam logic [CharW-1:0] UpperLast  = 8'h5a;
  localparam logic [CharW-1:0] CaseOffset = 8'h20;

  typedef logic [MaxPatternChars-1:0] vec_t;

  // decoded configuration seen by the matcher
  typedef struct packed {
    logic [MaxPatterns-1:0]                           active_mask;
    logic [MaxPatterns-1:0][MaxPatternChars-1:0][CharW-1:0] chars;
    logic [MaxPatterns-1:0][MaxPatternChars-1:0]      char_mask;
    logic [MaxPatterns-1:0][MaxPatternChars-1:0]      end_mask;
  } cfg_t;

  // line verdict
  typedef struct packed {
    logic                   keep_line;
    logic [MaxPatterns-1:0] patterns_found;
  } result_t;

  // fold ascii upper case to lower case, other bytes unchanged
  function automatic logic [CharW-1:0] fold_case(input logic [CharW-1:0] c);
    logic [CharW-1:0] r;
    r = c;
    if (c >= UpperFirst && c <= UpperLast) begin
      r = c + CaseOffset;
    end
    return r;
  endfunction

endpackage

FILE: design/mplf_ifs.sv
// valid/ready channel interfaces of the line filter
// depends on mplf_pkg
interface mplf_text_if;
  logic                       valid;
  logic                       ready;
  logic [mplf_pkg::CharW-1:0] text_char;
  logic                       has_char;
  logic                       line_end;

  modport source (output valid, output text_char, output has_char, output line_end,
                  input ready);
  modport sink (input valid, input text_char, input has_char, input line_end,
                output ready);
endinterface

interface mplf_result_if;
  logic                             valid;
  logic                             ready;
  logic                             keep_line;
  logic [mplf_pkg::MaxPatterns-1:0] patterns_found;

  modport source (output valid, output keep_line, output patterns_found, input ready);
  modport sink (input valid, input keep_line, input patterns_found, output ready);
endinterface

FILE: design/mplf_cfg.sv
// configuration registers and their decode into match masks
// depends on mplf_pkg
module mplf_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [mplf_pkg::IndexW-1:0]   wr_index,
  input  logic [mplf_pkg::DataW-1:0]    wr_data,
  output mplf_pkg::cfg_t                cfg
);

  logic [mplf_pkg::CountW-1:0] pattern_count;
  logic [mplf_pkg::MaxPatterns-1:0][mplf_pkg::MaxPatternChars-1:0][mplf_pkg::CharW-1:0]
    pattern_chars;
  logic [mplf_pkg::MaxPatterns-1:0][mplf_pkg::LenW-1:0] pattern_lengths;

  logic [mplf_pkg::CountW-1:0] count_eff;
  logic [mplf_pkg::LenW-1:0]   len_eff;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_count   <= mplf_pkg::CountReset;
      pattern_chars   <= '0;
      pattern_lengths <= '0;
    end else if (wr_en) begin
      if (wr_index == mplf_pkg::RegPatternCount) begin
        pattern_count <= wr_data[mplf_pkg::CountW-1:0];
      end
      if (wr_index == mplf_pkg::RegPatternLengths) begin
        pattern_lengths <= wr_data[mplf_pkg::MaxPatterns*mplf_pkg::LenW-1:0];
      end
      for (int p = 0; p < mplf_pkg::MaxPatterns; p++) begin
        if (wr_index == mplf_pkg::IndexW'(mplf_pkg::RegPatternZero + p)) begin
          pattern_chars[p] <= wr_data[mplf_pkg::MaxPatternChars*mplf_pkg::CharW-1:0];
        end
      end
    end
  end

  // clamp count and lengths, build per-pattern masks
  always_comb begin
    count_eff = pattern_count;
    if (count_eff == '0) begin
      count_eff = mplf_pkg::CountW'(1);
    end
    if (count_eff > mplf_pkg::CountW'(mplf_pkg::MaxPatterns)) begin
      count_eff = mplf_pkg::CountW'(mplf_pkg::MaxPatterns);
    end
    cfg = '0;
    len_eff = '0;
    for (int p = 0; p < mplf_pkg::MaxPatterns; p++) begin
      cfg.active_mask[p] = (mplf_pkg::CountW'(p) < count_eff);
      len_eff = pattern_lengths[p];
      if (len_eff > mplf_pkg::LenW'(mplf_pkg::MaxPatternChars)) begin
        len_eff = mplf_pkg::LenW'(mplf_pkg::MaxPatternChars);
      end
      for (int i = 0; i < mplf_pkg::MaxPatternChars; i++) begin
        cfg.chars[p][i]     = mplf_pkg::fold_case(pattern_chars[p][i]);
        cfg.char_mask[p][i] = (mplf_pkg::LenW'(i) < len_eff);
        cfg.end_mask[p][i]  = (mplf_pkg::LenW'(i + 1) == len_eff);
      end
    end
  end

endmodule

FILE: design/mplf_match.sv
// shift-and match vectors and found flags, one character per step
// depends on mplf_pkg and assert_macros.svh
`include "assert_macros.svh"

module mplf_match (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  logic [mplf_pkg::CharW-1:0]  text_char,
  input  logic                        has_char,
  input  logic                        line_end,
  input  mplf_pkg::cfg_t              cfg,
  output mplf_pkg::result_t           res
);

  mplf_pkg::vec_t [mplf_pkg::MaxPatterns-1:0] progress;
  mplf_pkg::vec_t [mplf_pkg::MaxPatterns-1:0] progress_next;
  logic [mplf_pkg::MaxPatterns-1:0]           found;
  logic [mplf_pkg::MaxPatterns-1:0]           found_next;

  logic [mplf_pkg::CharW-1:0]                 c;
  mplf_pkg::vec_t [mplf_pkg::MaxPatterns-1:0] eq;
  mplf_pkg::vec_t [mplf_pkg::MaxPatterns-1:0] vec;
  logic [mplf_pkg::MaxPatterns-1:0]           hit;
  logic [mplf_pkg::MaxPatterns-1:0]           found_upd;

  // compare character against every pattern position and advance vectors
  always_comb begin
    c = mplf_pkg::fold_case(text_char);
    for (int p = 0; p < mplf_pkg::MaxPatterns; p++) begin
      for (int i = 0; i < mplf_pkg::MaxPatternChars; i++) begin
        eq[p][i] = cfg.char_mask[p][i] && (cfg.chars[p][i] == c);
      end
      vec[p] = ((progress[p] << 1) | mplf_pkg::MaxPatternChars'(1)) & eq[p];
      hit[p] = |(vec[p] & cfg.end_mask[p]);
    end
    found_upd = has_char ? (found | hit) : found;
  end

  // line verdict including the current character
  always_comb begin
    res.patterns_found = found_upd & cfg.active_mask;
    res.keep_line      = (res.patterns_found == cfg.active_mask);
  end

  // next state: clear at line end, hold on items without a character
  always_comb begin
    if (line_end) begin
      progress_next = '0;
      found_next    = '0;
    end else if (has_char) begin
      progress_next = vec;
      found_next    = found_upd;
    end else begin
      progress_next = progress;
      found_next    = found;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      progress <= '0;
      found    <= '0;
    end else if (step) begin
      progress <= progress_next;
      found    <= found_next;
    end
  end

  // checks
  `ASSERT_CLK(a_line_end_clears, clk, rst, (step && line_end) |=> (found == '0 && progress == '0))
  `ASSERT_CLK(a_no_char_holds, clk, rst, (step && !has_char && !line_end) |=> $stable(found))
  `ASSERT_CLK(a_idle_holds, clk, rst, !step |=> ($stable(found) && $stable(progress)))

endmodule

FILE: design/multi_pattern_nocase_line_filter.sv
// Multi-pattern case-insensitive line filter. A line arrives one character per
// transaction on text; the last transaction of the line (line_end) produces one
// transaction on result telling whether every active pattern (one to four, up to
// eight characters each, ASCII letters compared without case) occurred in the line.
// One character is taken every clock cycle while the input does not stall: the match
// vectors of all patterns advance straight from the input register. A verdict moves
// from the input register into an output register, which holds it while text keeps
// flowing; only a second line end meeting an untaken verdict stalls the input.
// Configuration registers are written with wr_en/wr_index/wr_data; the user must write
// them only while no line is in flight, which the block itself does not enforce.
// depends on mplf_pkg, mplf_ifs, mplf_cfg, mplf_match and assert_macros.svh
`include "assert_macros.svh"

module multi_pattern_nocase_line_filter (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         wr_en,
  input  logic [mplf_pkg::IndexW-1:0]  wr_index,
  input  logic [mplf_pkg::DataW-1:0]   wr_data,
  mplf_text_if.sink                    text,
  mplf_result_if.source                result
);

  mplf_pkg::cfg_t    cfg;
  mplf_pkg::result_t res;

  // input register
  logic                       in_valid;
  logic [mplf_pkg::CharW-1:0] in_char;
  logic                       in_has_char;
  logic                       in_line_end;

  // output register
  logic                             out_valid;
  logic                             out_keep_line;
  logic [mplf_pkg::MaxPatterns-1:0] out_found;

  logic advance;
  logic load_out;

  mplf_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  mplf_match u_match (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .text_char (in_char),
    .has_char  (in_has_char),
    .line_end  (in_line_end),
    .cfg       (cfg),
    .res       (res)
  );

  // flow control: a line end needs room in the output register
  always_comb begin
    advance    = in_valid && (!in_line_end || !out_valid || result.ready);
    load_out   = advance && in_line_end;
    text.ready = !in_valid || advance;
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (text.ready) begin
      in_valid <= text.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (text.ready && text.valid) begin
      in_char     <= text.text_char;
      in_has_char <= text.has_char;
      in_line_end <= text.line_end;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_keep_line <= res.keep_line;
      out_found     <= res.patterns_found;
    end
  end

  assign result.valid          = out_valid;
  assign result.keep_line      = out_keep_line;
  assign result.patterns_found = out_found;

  // checks
  `ASSERT_CLK(a_verdict_from_line_end, clk, rst, $rose(out_valid) |-> $past(load_out))
  `ASSERT_CLK(a_no_overwrite, clk, rst, (out_valid && !result.ready) |-> !load_out)
  `ASSERT_CLK(a_stalled_item_kept, clk, rst,
              (in_valid && !advance) |=> (in_valid && $stable(in_char) && $stable(in_line_end)))

endmodule
